/* rtl/setwe_pkg.sv */
package setwe_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [31:0] STALE_WINDOW_RESET = 32'd86400;

   // command codes
   localparam logic [1:0] CMD_UPSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_PRUNE  = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   // result status codes
   localparam logic [1:0] STS_DONE    = 2'd0;
   localparam logic [1:0] STS_IGNORED = 2'd1;
   localparam logic [1:0] STS_BEYOND  = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_NEXT,
      OP_WRITE,
      OP_SWAP_LEFT,
      OP_SWAP_RIGHT,
      OP_REMOVE,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      SEL_POS,
      SEL_LEFT,
      SEL_RIGHT,
      SEL_READ
   } sel_type;

   typedef struct packed {
      op_type     op;
      sel_type    sel;
      logic [1:0] code;
      logic       changed;
   } dp_ctl_type;

   typedef struct packed {
      logic [1:0] req_cmd;
      logic       req_id_zero;
      logic [1:0] cmd;
      logic       match;
      logic       at_end;
      logic       left_gt;
      logic       right_lt;
      logic       stale;
      logic       lim_ok;
      logic       rd_beyond;
      logic       out_busy;
   } dp_sts_type;

endpackage

/* rtl/sorted_event_table_with_eviction_unit.sv */
// Sorted event table: sixteen (id, start, end) slots kept stably sorted by
// start, occupied slots first. One item is worked on at a time; req_stall is
// high from acceptance until the result is loaded into the output register,
// and the next item is taken while that result still waits. Each item is
// worked by a single shared compare unit stepping through the slots: read
// and zero-id items go straight to the result, delete searches for the id
// and removes it if found, prune visits each occupied slot, keeping or
// removing it, unless its limit underflows, and upsert does the id search,
// the write and the two bubble stop checks and moves the entry one position
// at a time while it is bubbled into place. An item also waits in its last
// state while a previous result stays stalled. The stale window register is
// written through csr_valid/csr_ready (always ready) and must only be
// written while the block is idle.
module sorted_event_table_with_eviction_unit (
   input  logic               clock,
   input  logic               reset,
   // request items
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [31:0]        req_entry_id,
   input  logic signed [63:0] req_start_time,
   input  logic signed [63:0] req_end_time,
   input  logic signed [63:0] req_now_time,
   input  logic [3:0]         req_read_index,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic               rsp_changed,
   output logic [4:0]         rsp_valid_count,
   output logic [31:0]        rsp_read_id,
   output logic signed [63:0] rsp_read_start,
   output logic signed [63:0] rsp_read_end,
   // stale window register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_stale_window
);

   setwe_pkg::dp_ctl_type ctl;
   setwe_pkg::dp_sts_type sts;
   logic                  csr_write;

   // register port never back-pressures
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // sequencer: search, bubble, compaction and result handoff
   setwe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // slot cells, shared compare unit, output register
   setwe_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_entry_id     (req_entry_id),
      .req_start_time   (req_start_time),
      .req_end_time     (req_end_time),
      .req_now_time     (req_now_time),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_changed      (rsp_changed),
      .rsp_valid_count  (rsp_valid_count),
      .rsp_read_id      (rsp_read_id),
      .rsp_read_start   (rsp_read_start),
      .rsp_read_end     (rsp_read_end),
      .csr_valid        (csr_write),
      .csr_stale_window (csr_stale_window),
      .ctl              (ctl),
      .sts              (sts)
   );

endmodule

/* rtl/setwe_ctrl.sv */
module setwe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  setwe_pkg::dp_sts_type  sts,
   output setwe_pkg::dp_ctl_type  ctl
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN   = 7'b0000010,
      S_WRITE  = 7'b0000100,
      S_LEFT   = 7'b0001000,
      S_RIGHT  = 7'b0010000,
      S_PRUNE  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] code_ff, code_in;
   logic       chg_ff, chg_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      code_in     = code_ff;
      chg_in      = chg_ff;
      ctl.op      = setwe_pkg::OP_NONE;
      ctl.sel     = setwe_pkg::SEL_POS;
      ctl.code    = code_ff;
      ctl.changed = chg_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.op  = setwe_pkg::OP_LOAD;
               chg_in  = 1'b0;
               code_in = setwe_pkg::STS_DONE;
               case (sts.req_cmd) inside
                  setwe_pkg::CMD_UPSERT, setwe_pkg::CMD_DELETE: begin
                     if (sts.req_id_zero) begin
                        code_in  = setwe_pkg::STS_IGNORED;
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  setwe_pkg::CMD_PRUNE: state_in = S_PRUNE;
                  default:              state_in = S_FINISH;
               endcase
            end
         end
         S_SCAN: begin
            if (sts.match) begin
               if (sts.cmd == setwe_pkg::CMD_UPSERT) begin
                  state_in = S_WRITE;
               end else begin
                  ctl.op   = setwe_pkg::OP_REMOVE;
                  chg_in   = 1'b1;
                  state_in = S_FINISH;
               end
            end else if (sts.at_end) begin
               if (sts.cmd == setwe_pkg::CMD_UPSERT) begin
                  state_in = S_WRITE;
               end else begin
                  code_in  = setwe_pkg::STS_IGNORED;
                  state_in = S_FINISH;
               end
            end else begin
               ctl.op = setwe_pkg::OP_NEXT;
            end
         end
         S_WRITE: begin
            ctl.op   = setwe_pkg::OP_WRITE;
            chg_in   = 1'b1;
            state_in = S_LEFT;
         end
         S_LEFT: begin
            ctl.sel = setwe_pkg::SEL_LEFT;
            if (sts.left_gt) begin
               ctl.op = setwe_pkg::OP_SWAP_LEFT;
            end else begin
               state_in = S_RIGHT;
            end
         end
         S_RIGHT: begin
            ctl.sel = setwe_pkg::SEL_RIGHT;
            if (sts.right_lt) begin
               ctl.op = setwe_pkg::OP_SWAP_RIGHT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_PRUNE: begin
            if (!sts.lim_ok || sts.at_end) begin
               state_in = S_FINISH;
            end else if (sts.stale) begin
               ctl.op = setwe_pkg::OP_REMOVE;
               chg_in = 1'b1;
            end else begin
               ctl.op = setwe_pkg::OP_NEXT;
            end
         end
         S_FINISH: begin
            ctl.sel = setwe_pkg::SEL_READ;
            if (sts.cmd == setwe_pkg::CMD_READ) begin
               ctl.code = sts.rd_beyond ? setwe_pkg::STS_BEYOND : setwe_pkg::STS_DONE;
            end
            if (!sts.out_busy) begin
               ctl.op   = setwe_pkg::OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= setwe_pkg::STS_DONE;
         chg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         chg_ff   <= chg_in;
      end
   end

endmodule

/* rtl/setwe_dp.sv */
module setwe_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_cmd,
   input  logic [31:0]            req_entry_id,
   input  logic signed [63:0]     req_start_time,
   input  logic signed [63:0]     req_end_time,
   input  logic signed [63:0]     req_now_time,
   input  logic [3:0]             req_read_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic                   rsp_changed,
   output logic [4:0]             rsp_valid_count,
   output logic [31:0]            rsp_read_id,
   output logic signed [63:0]     rsp_read_start,
   output logic signed [63:0]     rsp_read_end,
   input  logic                   csr_valid,
   input  logic [31:0]            csr_stale_window,
   input  setwe_pkg::dp_ctl_type  ctl,
   output setwe_pkg::dp_sts_type  sts
);

   localparam int D = setwe_pkg::TABLE_DEPTH;
   localparam int IW = setwe_pkg::IDX_W;
   localparam int CW = setwe_pkg::CNT_W;

   // sorted table cells, occupied ones first
   logic [31:0]        id_ff [D];
   logic signed [63:0] st_ff [D];
   logic signed [63:0] en_ff [D];
   logic [31:0]        id_in [D];
   logic signed [63:0] st_in [D];
   logic signed [63:0] en_in [D];

   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [31:0]        window_ff;
   logic [1:0]         cmd_ff;
   logic [31:0]        key_id_ff;
   logic signed [63:0] key_st_ff;
   logic signed [63:0] key_en_ff;
   logic [IW-1:0]      ridx_ff;
   logic               ridx_ok_ff;
   logic signed [63:0] lim_ff;
   logic               lim_ok_ff;
   logic               out_valid_ff;

   logic [1:0]         r_status_ff;
   logic               r_changed_ff;
   logic [4:0]         r_count_ff;
   logic [31:0]        r_id_ff;
   logic signed [63:0] r_st_ff;
   logic signed [63:0] r_en_ff;

   logic signed [64:0] diff;
   logic [CW-1:0]      pos_m1, pos_p1;
   logic [IW-1:0]      pos_idx, rd_addr, wr_idx;
   logic [31:0]        rd_id;
   logic signed [63:0] rd_st, rd_en;
   logic               in_range;
   logic               full_wrap;

   assign diff    = {req_now_time[63], req_now_time} - 65'($unsigned(window_ff));
   assign pos_m1  = pos_ff - 1'b1;
   assign pos_p1  = pos_ff + 1'b1;
   assign pos_idx = pos_ff[IW-1:0];

   // single read port, address chosen by sequencer state
   always_comb begin
      case (ctl.sel)
         setwe_pkg::SEL_LEFT:  rd_addr = pos_m1[IW-1:0];
         setwe_pkg::SEL_RIGHT: rd_addr = pos_p1[IW-1:0];
         setwe_pkg::SEL_READ:  rd_addr = ridx_ff;
         default:              rd_addr = pos_idx;
      endcase
   end
   assign rd_id = id_ff[rd_addr];
   assign rd_st = st_ff[rd_addr];
   assign rd_en = en_ff[rd_addr];

   assign in_range  = (pos_ff < cnt_ff);
   assign full_wrap = (pos_ff == cnt_ff) && (cnt_ff == CW'(D));
   assign wr_idx    = full_wrap ? '0 : pos_idx;

   assign sts.req_cmd     = req_cmd;
   assign sts.req_id_zero = (req_entry_id == '0);
   assign sts.cmd         = cmd_ff;
   assign sts.match       = in_range && (rd_id == key_id_ff);
   assign sts.at_end      = (pos_ff == cnt_ff);
   assign sts.left_gt     = (pos_ff != '0) && (rd_st > key_st_ff);
   assign sts.right_lt    = (pos_p1 < cnt_ff) && (rd_st < key_st_ff);
   assign sts.stale       = in_range && (rd_id != '0) && (rd_st != '0) && (rd_st < lim_ff);
   assign sts.lim_ok      = lim_ok_ff;
   assign sts.rd_beyond   = !ridx_ok_ff;
   assign sts.out_busy    = out_valid_ff && rsp_stall;

   always_comb begin
      id_in  = id_ff;
      st_in  = st_ff;
      en_in  = en_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      case (ctl.op)
         setwe_pkg::OP_LOAD: pos_in = '0;
         setwe_pkg::OP_NEXT: pos_in = pos_p1;
         setwe_pkg::OP_WRITE: begin
            id_in[wr_idx] = key_id_ff;
            st_in[wr_idx] = key_st_ff;
            en_in[wr_idx] = key_en_ff;
            if (full_wrap) begin
               pos_in = '0;
            end else if (pos_ff == cnt_ff) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         setwe_pkg::OP_SWAP_LEFT: begin
            id_in[pos_idx]           = rd_id;
            st_in[pos_idx]           = rd_st;
            en_in[pos_idx]           = rd_en;
            id_in[pos_m1[IW-1:0]]    = key_id_ff;
            st_in[pos_m1[IW-1:0]]    = key_st_ff;
            en_in[pos_m1[IW-1:0]]    = key_en_ff;
            pos_in                   = pos_m1;
         end
         setwe_pkg::OP_SWAP_RIGHT: begin
            id_in[pos_idx]           = rd_id;
            st_in[pos_idx]           = rd_st;
            en_in[pos_idx]           = rd_en;
            id_in[pos_p1[IW-1:0]]    = key_id_ff;
            st_in[pos_p1[IW-1:0]]    = key_st_ff;
            en_in[pos_p1[IW-1:0]]    = key_en_ff;
            pos_in                   = pos_p1;
         end
         setwe_pkg::OP_REMOVE: begin
            // close the gap: every cell at or above pos takes its upper neighbor, the top cell is cleared
            for (int j = 0; j < D; j++) begin
               if (CW'(j) >= pos_ff) begin
                  if (j == D - 1) begin
                     id_in[j] = '0;
                     st_in[j] = '0;
                     en_in[j] = '0;
                  end else begin
                     id_in[j] = id_ff[j + 1];
                     st_in[j] = st_ff[j + 1];
                     en_in[j] = en_ff[j + 1];
                  end
               end
            end
            cnt_in = cnt_ff - 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.op == setwe_pkg::OP_LOAD) begin
         cmd_ff     <= req_cmd;
         key_id_ff  <= req_entry_id;
         key_st_ff  <= req_start_time;
         key_en_ff  <= req_end_time;
         ridx_ff    <= IW'(req_read_index);
         ridx_ok_ff <= (32'(req_read_index) < 32'(cnt_ff));
         lim_ff     <= diff[63:0];
         lim_ok_ff  <= (diff[64] == diff[63]);
      end
      if (ctl.op == setwe_pkg::OP_FINISH) begin
         r_status_ff  <= ctl.code;
         r_changed_ff <= ctl.changed;
         r_count_ff   <= 5'(cnt_ff);
         if (cmd_ff == setwe_pkg::CMD_READ && ctl.code == setwe_pkg::STS_DONE) begin
            r_id_ff <= rd_id;
            r_st_ff <= rd_st;
            r_en_ff <= rd_en;
         end else begin
            r_id_ff <= '0;
            r_st_ff <= '0;
            r_en_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff        <= '{default: '0};
         st_ff        <= '{default: '0};
         en_ff        <= '{default: '0};
         pos_ff       <= '0;
         cnt_ff       <= '0;
         window_ff    <= setwe_pkg::STALE_WINDOW_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         id_ff  <= id_in;
         st_ff  <= st_in;
         en_ff  <= en_in;
         pos_ff <= pos_in;
         cnt_ff <= cnt_in;
         if (csr_valid) begin
            window_ff <= csr_stale_window;
         end
         if (ctl.op == setwe_pkg::OP_FINISH) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = r_status_ff;
   assign rsp_changed     = r_changed_ff;
   assign rsp_valid_count = r_count_ff;
   assign rsp_read_id     = r_id_ff;
   assign rsp_read_start  = r_st_ff;
   assign rsp_read_end    = r_en_ff;

endmodule

/* rtl/setwe_checker.sv */
module setwe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_changed,
   input logic [4:0]  rsp_valid_count,
   input logic [31:0] rsp_read_id
);

   // held result item keeps its status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result item changed while stalled");

   // busy right after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous one in work");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_valid_count <= 5'(setwe_pkg::TABLE_DEPTH))
      else $error("count beyond table depth");

   a_beyond: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == setwe_pkg::STS_BEYOND |-> !rsp_changed && rsp_read_id == '0)
      else $error("out of range read returned data or changed table");

   a_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_changed |-> rsp_status == setwe_pkg::STS_DONE)
      else $error("change reported on a failed item");

endmodule

bind sorted_event_table_with_eviction_unit setwe_checker u_setwe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_changed     (rsp_changed),
   .rsp_valid_count (rsp_valid_count),
   .rsp_read_id     (rsp_read_id)
);

/* sim/sorted_event_table_with_eviction_unit_test.sv */
module sorted_event_table_with_eviction_unit_test;

   // one request item as driven on the req_ ports
   typedef struct {
      logic [1:0]         cmd;
      logic [31:0]        id;
      logic signed [63:0] st;
      logic signed [63:0] en;
      logic signed [63:0] now;
      logic [3:0]         ridx;
   } event_req_type;

   // one result item as seen on the rsp_ ports
   typedef struct {
      logic [1:0]         status;
      logic               changed;
      logic [4:0]         count;
      logic [31:0]        rid;
      logic signed [63:0] rst;
      logic signed [63:0] ren;
   } event_rsp_type;

   localparam int STALL_LIMIT = 5000;
   localparam int DEPTH = setwe_pkg::TABLE_DEPTH;
   localparam logic signed [63:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] TIME_MIN = 64'sh8000_0000_0000_0000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_cmd;
   logic [31:0]        req_entry_id;
   logic signed [63:0] req_start_time;
   logic signed [63:0] req_end_time;
   logic signed [63:0] req_now_time;
   logic [3:0]         req_read_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic               rsp_changed;
   logic [4:0]         rsp_valid_count;
   logic [31:0]        rsp_read_id;
   logic signed [63:0] rsp_read_start;
   logic signed [63:0] rsp_read_end;
   logic               csr_valid;
   logic               csr_ready;
   logic [31:0]        csr_stale_window;

   sorted_event_table_with_eviction_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_entry_id(req_entry_id), .req_start_time(req_start_time),
      .req_end_time(req_end_time), .req_now_time(req_now_time),
      .req_read_index(req_read_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_changed(rsp_changed), .rsp_valid_count(rsp_valid_count),
      .rsp_read_id(rsp_read_id), .rsp_read_start(rsp_read_start),
      .rsp_read_end(rsp_read_end),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_stale_window(csr_stale_window)
   );

   // predicted table contents, kept sorted like the hardware
   logic [31:0]        tbl_id [DEPTH];
   logic signed [63:0] tbl_st [DEPTH];
   logic signed [63:0] tbl_en [DEPTH];
   int                 tbl_count;
   logic [31:0]        window_shadow;

   event_req_type pending_reqs[$];
   event_rsp_type expected_rsps[$];

   int  send_idle_pct;
   int  recv_idle_pct;
   int  errors;
   int  accepted_reqs;
   int  checked_rsps;
   int  quiet_cycles;
   int  evictions_seen;
   int  prunes_hit;
   bit  csr_req;
   logic [31:0] csr_value;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // a precedes b unless b is occupied and (a empty or a later start)
   function automatic bit keeps_order(logic [31:0] ida, logic signed [63:0] sa,
                                      logic [31:0] idb, logic signed [63:0] sb);
      if (ida == 0) return idb == 0;
      if (idb == 0) return 1'b1;
      return sa <= sb;
   endfunction

   // stable insertion sort, then recount occupied slots
   function automatic void resort_table();
      logic [31:0]        kid;
      logic signed [63:0] ks, ke;
      int                 j;
      for (int i = 1; i < DEPTH; i++) begin
         kid = tbl_id[i]; ks = tbl_st[i]; ke = tbl_en[i];
         j = i - 1;
         while (j >= 0 && !keeps_order(tbl_id[j], tbl_st[j], kid, ks)) begin
            tbl_id[j+1] = tbl_id[j]; tbl_st[j+1] = tbl_st[j]; tbl_en[j+1] = tbl_en[j];
            j--;
         end
         tbl_id[j+1] = kid; tbl_st[j+1] = ks; tbl_en[j+1] = ke;
      end
      tbl_count = 0;
      for (int i = 0; i < DEPTH; i++)
         if (tbl_id[i] != 0) tbl_count++;
   endfunction

   function automatic int choose_upsert_slot(logic [31:0] id);
      int                 empty_at;
      int                 oldest_at;
      logic signed [63:0] oldest_st;
      empty_at = -1;
      oldest_at = 0;
      oldest_st = TIME_MAX;
      for (int i = 0; i < DEPTH; i++)
         if (tbl_id[i] == id) return i;
      for (int i = 0; i < DEPTH; i++) begin
         if (tbl_id[i] == 0) begin
            if (empty_at < 0) empty_at = i;
         end else if (tbl_st[i] < oldest_st) begin
            oldest_st = tbl_st[i];
            oldest_at = i;
         end
      end
      if (empty_at < 0) evictions_seen++;
      return (empty_at >= 0) ? empty_at : oldest_at;
   endfunction

   // advance the predicted table by one item and return its result
   function automatic event_rsp_type predict_table_op(event_req_type r);
      event_rsp_type      res;
      int                 s;
      logic signed [64:0] wide_lim;
      logic signed [63:0] lim;
      res = '{status: setwe_pkg::STS_DONE, changed: 1'b0, count: '0, rid: '0,
              rst: '0, ren: '0};
      case (r.cmd)
         setwe_pkg::CMD_UPSERT: begin
            if (r.id == 0) begin
               res.status = setwe_pkg::STS_IGNORED;
            end else begin
               s = choose_upsert_slot(r.id);
               tbl_id[s] = r.id; tbl_st[s] = r.st; tbl_en[s] = r.en;
               resort_table();
               res.changed = 1'b1;
            end
         end
         setwe_pkg::CMD_DELETE: begin
            res.status = setwe_pkg::STS_IGNORED;
            if (r.id != 0) begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (tbl_id[i] == r.id) begin
                     tbl_id[i] = 0; tbl_st[i] = 0; tbl_en[i] = 0;
                     resort_table();
                     res.changed = 1'b1;
                     res.status = setwe_pkg::STS_DONE;
                     break;
                  end
               end
            end
         end
         setwe_pkg::CMD_PRUNE: begin
            // 65-bit subtract so an underflowing limit is detected
            wide_lim = $signed({r.now[63], r.now}) - $signed({33'd0, window_shadow});
            if (wide_lim >= $signed({TIME_MIN[63], TIME_MIN})) begin
               lim = wide_lim[63:0];
               for (int i = 0; i < DEPTH; i++) begin
                  if (tbl_id[i] != 0 && tbl_st[i] != 0 && tbl_st[i] < lim) begin
                     tbl_id[i] = 0; tbl_st[i] = 0; tbl_en[i] = 0;
                     res.changed = 1'b1;
                  end
               end
               if (res.changed) begin
                  resort_table();
                  prunes_hit++;
               end
            end
         end
         default: begin
            if (int'(r.ridx) < tbl_count) begin
               res.rid = tbl_id[r.ridx];
               res.rst = tbl_st[r.ridx];
               res.ren = tbl_en[r.ridx];
            end else begin
               res.status = setwe_pkg::STS_BEYOND;
            end
         end
      endcase
      res.count = tbl_count[4:0];
      return res;
   endfunction

   function automatic logic signed [63:0] rand_time64();
      return {$urandom, $urandom};
   endfunction

   function automatic event_req_type make_req(logic [1:0] cmd, logic [31:0] id,
                                              logic signed [63:0] st,
                                              logic signed [63:0] en,
                                              logic signed [63:0] now,
                                              logic [3:0] ridx);
      event_req_type r;
      r.cmd = cmd; r.id = id; r.st = st; r.en = en; r.now = now; r.ridx = ridx;
      return r;
   endfunction

   // random item; ids from a small pool so hits, updates and evictions happen
   function automatic event_req_type rand_req();
      event_req_type r;
      int            pick;
      r.cmd  = 2'($urandom_range(0, 3));
      pick   = $urandom_range(0, 99);
      if (pick < 4)       r.id = 0;
      else if (pick < 85) r.id = $urandom_range(1, 24);
      else                r.id = $urandom;
      // starts mostly clustered near a base so prune has something to cut
      pick = $urandom_range(0, 99);
      if (pick < 10)      r.st = 0;
      else if (pick < 20) r.st = rand_time64();
      else if (pick < 25) r.st = (pick & 1) ? TIME_MAX : TIME_MIN;
      else                r.st = 64'sd1000000 + $urandom_range(0, 400000);
      r.en  = rand_time64();
      pick  = $urandom_range(0, 99);
      if (pick < 15)      r.now = rand_time64();
      else if (pick < 20) r.now = TIME_MIN + $urandom_range(0, 100000);
      else                r.now = 64'sd1000000 + $urandom_range(0, 600000);
      r.ridx = 4'($urandom);
      if (r.cmd == setwe_pkg::CMD_PRUNE && $urandom_range(0, 2) != 0)
         r.cmd = setwe_pkg::CMD_UPSERT;
      return r;
   endfunction

   // request driver: pops pending items, holds payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid      <= 1'b1;
            req_cmd        <= pending_reqs[0].cmd;
            req_entry_id   <= pending_reqs[0].id;
            req_start_time <= pending_reqs[0].st;
            req_end_time   <= pending_reqs[0].en;
            req_now_time   <= pending_reqs[0].now;
            req_read_index <= pending_reqs[0].ridx;
            void'(pending_reqs.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // prediction at acceptance, in order of acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_rsps.push_back(predict_table_op(make_req(req_cmd, req_entry_id,
            req_start_time, req_end_time, req_now_time, req_read_index)));
         accepted_reqs++;
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      event_rsp_type exp_rsp;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_rsps++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result status=%0d count=%0d", $time,
                        rsp_status, rsp_valid_count);
               errors++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_status !== exp_rsp.status || rsp_changed !== exp_rsp.changed ||
                   rsp_valid_count !== exp_rsp.count || rsp_read_id !== exp_rsp.rid ||
                   rsp_read_start !== exp_rsp.rst || rsp_read_end !== exp_rsp.ren) begin
                  $display("%0t: mismatch expected sts=%0d chg=%0d cnt=%0d id=%h st=%h en=%h",
                           $time, exp_rsp.status, exp_rsp.changed, exp_rsp.count,
                           exp_rsp.rid, exp_rsp.rst, exp_rsp.ren);
                  $display("%0t:          actual   sts=%0d chg=%0d cnt=%0d id=%h st=%h en=%h",
                           $time, rsp_status, rsp_changed, rsp_valid_count,
                           rsp_read_id, rsp_read_start, rsp_read_end);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // register write port; the test only raises csr_req while idle
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         csr_valid <= 1'b0;
         window_shadow <= csr_stale_window;
      end else if (csr_req && !csr_valid) begin
         csr_valid        <= 1'b1;
         csr_stale_window <= csr_value;
      end
   end

   // watchdog: cycles with no item moving on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     expected_rsps.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      // then let the bench idle on after the last result
      repeat (40) @(posedge clock);
   endtask

   task automatic write_window(logic [31:0] value);
      csr_value = value;
      csr_req   = 1'b1;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      csr_req = 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random(int count);
      repeat (count) pending_reqs.push_back(rand_req());
      wait_drained();
   endtask

   initial begin
      errors = 0; accepted_reqs = 0; checked_rsps = 0; evictions_seen = 0;
      prunes_hit = 0; csr_req = 0; csr_value = '0;
      send_idle_pct = 25; recv_idle_pct = 66;
      window_shadow = setwe_pkg::STALE_WINDOW_RESET;
      tbl_count = 0;
      for (int i = 0; i < DEPTH; i++) begin
         tbl_id[i] = 0; tbl_st[i] = 0; tbl_en[i] = 0;
      end
      reset = 1'b1;
      req_valid = 1'b0; req_cmd = setwe_pkg::CMD_READ; req_entry_id = '0;
      req_start_time = '0; req_end_time = '0; req_now_time = '0; req_read_index = '0;
      rsp_stall = 1'b0; csr_valid = 1'b0; csr_stale_window = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty reads, zero ids, unknown delete, extremes
      pending_reqs.push_back(make_req(setwe_pkg::CMD_READ, 0, 0, 0, 0, 4'd0));
      pending_reqs.push_back(make_req(setwe_pkg::CMD_UPSERT, 0, 5, 5, 0, 0));
      pending_reqs.push_back(make_req(setwe_pkg::CMD_DELETE, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(setwe_pkg::CMD_DELETE, 32'd77, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(setwe_pkg::CMD_UPSERT, 32'hFFFF_FFFF, TIME_MAX,
                                      TIME_MIN, 0, 0));
      pending_reqs.push_back(make_req(setwe_pkg::CMD_UPSERT, 32'd1, TIME_MIN, TIME_MAX,
                                      0, 0));
      pending_reqs.push_back(make_req(setwe_pkg::CMD_UPSERT, 32'd2, 0, -64'sd1, 0, 0));
      // rewrite with identical values still reports a change
      pending_reqs.push_back(make_req(setwe_pkg::CMD_UPSERT, 32'd2, 0, -64'sd1, 0, 0));
      pending_reqs.push_back(make_req(setwe_pkg::CMD_READ, 0, 0, 0, 0, 4'd0));
      pending_reqs.push_back(make_req(setwe_pkg::CMD_READ, 0, 0, 0, 0, 4'd2));
      pending_reqs.push_back(make_req(setwe_pkg::CMD_READ, 0, 0, 0, 0, 4'd3));
      pending_reqs.push_back(make_req(setwe_pkg::CMD_READ, 0, 0, 0, 0, 4'd15));
      // prune with now near the lowest time: nothing stale
      pending_reqs.push_back(make_req(setwe_pkg::CMD_PRUNE, 32'd9, 0, 0, TIME_MIN + 5, 0));
      // prune at the top: every nonzero start more than the window below the maximum
      pending_reqs.push_back(make_req(setwe_pkg::CMD_PRUNE, 0, 0, 0, TIME_MAX, 0));
      pending_reqs.push_back(make_req(setwe_pkg::CMD_DELETE, 32'd2, 0, 0, 0, 0));
      // full table of maximal starts, then one more to evict slot zero
      for (int i = 0; i < DEPTH; i++)
         pending_reqs.push_back(make_req(setwe_pkg::CMD_UPSERT, 32'(100 + i), TIME_MAX,
                                         64'(i), 0, 0));
      pending_reqs.push_back(make_req(setwe_pkg::CMD_UPSERT, 32'd200, 64'sd3, 64'sd4, 0, 0));
      pending_reqs.push_back(make_req(setwe_pkg::CMD_READ, 0, 0, 0, 0, 4'd15));
      wait_drained();

      // random phases across window settings and idling profiles
      write_window(32'd0);
      run_random(100);
      write_window(32'hFFFF_FFFF);
      run_random(100);
      send_idle_pct = 66; recv_idle_pct = 25;
      write_window(32'd100000);
      run_random(150);
      write_window($urandom_range(1, 300000));
      run_random(100);
      send_idle_pct = 0; recv_idle_pct = 0;
      write_window(setwe_pkg::STALE_WINDOW_RESET);
      run_random(150);

      $display("covered %0d items, %0d results checked, %0d evictions, %0d pruning hits",
               accepted_reqs, checked_rsps, evictions_seen, prunes_hit);
      $display("five stale window settings including zero and all ones");
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sorted_event_table_with_eviction_unit.f */
rtl/setwe_pkg.sv
rtl/setwe_ctrl.sv
rtl/setwe_dp.sv
rtl/sorted_event_table_with_eviction_unit.sv
rtl/setwe_checker.sv
sim/sorted_event_table_with_eviction_unit_test.sv
